// ===== src/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// constants, codes and types shared by the multipart body extractor
// ----------------------------------------------------------------------------
package mbe_pkg;

    // default sizing
    localparam int MAX_BOUNDARY_DEF = 48;
    localparam int COUNT_WIDTH_DEF  = 40;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int BND_LEN_W  = 6;
    localparam int WORD_W     = 64;
    localparam int WORD_CNT   = 6;
    localparam int LIMIT_W    = 40;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD5  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 4'd7;

    typedef logic [STATUS_W-1:0] t_status;

    // result status codes
    localparam t_status ST_RUNNING = 3'd0;
    localparam t_status ST_DONE    = 3'd1;
    localparam t_status ST_ABORT   = 3'd2;
    localparam t_status ST_ENDED   = 3'd3;
    localparam t_status ST_IGNORED = 3'd4;

    // delimiter and header terminator bytes
    localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

endpackage

// ===== src/multipart_body_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipart_body_extractor
// extracts the first file part of a multipart body, one byte per transfer
// ----------------------------------------------------------------------------
// path: each input transfer is captured in the input register, then one pass
//   of window compare writes its result into the result register
// throughput: one byte per cycle unless the result channel stalls, set by the
//   parallel compare of the 50-byte match window against the delimiter
// reset: synchronous, active low; clears phase, fill, byte count, handshake
//   state and restores configuration defaults; no clearing pass is needed
module multipart_body_extractor #(
    parameter int MAX_BOUNDARY = mbe_pkg::MAX_BOUNDARY_DEF,
    parameter int COUNT_WIDTH  = mbe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mbe_pkg::WORD_W-1:0]        i_cfg_data,
    // body byte input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mbe_pkg::BYTE_W-1:0]        i_body_byte,
    input  logic                              i_last_byte,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_data_valid,
    output logic [mbe_pkg::BYTE_W-1:0]        o_file_byte,
    output logic [mbe_pkg::STATUS_W-1:0]      o_status
);

    // window holds the delimiter plus its two hyphens
    localparam int WIN   = MAX_BOUNDARY + 2;
    localparam int FW    = $clog2(WIN + 1);
    localparam int CNT_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (CNT_W > mbe_pkg::LIMIT_W) ? CNT_W : mbe_pkg::LIMIT_W;
    localparam int WSEL_W = $clog2(mbe_pkg::WORD_CNT);

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_HEAD,
        PH_DATA,
        PH_DONE,
        PH_ABORT,
        PH_ENDED
    } t_phase;

    // configuration
    logic [mbe_pkg::BND_LEN_W-1:0] r_bnd_len;
    logic [mbe_pkg::WORD_W-1:0]    r_bnd_word [mbe_pkg::WORD_CNT];
    logic [mbe_pkg::LIMIT_W-1:0]   r_size_limit;

    // input register
    logic                          r_in_valid;
    logic [mbe_pkg::BYTE_W-1:0]    r_in_byte;
    logic                          r_in_last;

    // parser state
    t_phase                        r_phase, n_phase;
    logic [mbe_pkg::BYTE_W-1:0]    r_win [WIN];
    logic [mbe_pkg::BYTE_W-1:0]    n_win [WIN];
    logic [FW-1:0]                 r_fill, n_fill;
    logic [CNT_W-1:0]              r_count, n_count;

    // result register
    logic                          r_out_valid;
    logic                          r_data_valid, n_data_valid;
    logic [mbe_pkg::BYTE_W-1:0]    r_file_byte, n_file_byte;
    mbe_pkg::t_status              r_status, n_status;

    logic                          w_fire;
    logic                          w_in_xfer;
    logic [mbe_pkg::BND_LEN_W-1:0] w_len_eff;
    logic [FW-1:0]                 w_dlen;
    logic [mbe_pkg::BYTE_W-1:0]    w_bnd_byte [MAX_BOUNDARY];
    logic [mbe_pkg::BYTE_W-1:0]    w_expect [WIN];
    logic                          w_pat_ok;
    logic                          w_head_ok;
    logic [mbe_pkg::BYTE_W-1:0]    w_release;
    logic [CNT_W-1:0]              w_count_inc;
    logic                          w_over;
    logic [FW-1:0]                 w_fill_base;
    logic [WSEL_W-1:0]             w_word_sel;

    // the stage advances when the result register is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_word_sel  = WSEL_W'(i_cfg_index - mbe_pkg::CFG_WORD0);

    assign o_out_valid  = r_out_valid;
    assign o_data_valid = r_data_valid;
    assign o_file_byte  = r_file_byte;
    assign o_status     = r_status;

    // effective delimiter length: zero acts as one, clamp at MAX_BOUNDARY
    always_comb begin
        if (r_bnd_len == '0) begin
            w_len_eff = mbe_pkg::BND_LEN_W'(1);
        end else if (int'(r_bnd_len) > MAX_BOUNDARY) begin
            w_len_eff = mbe_pkg::BND_LEN_W'(MAX_BOUNDARY);
        end else begin
            w_len_eff = r_bnd_len;
        end
        w_dlen = FW'(w_len_eff) + FW'(2);
    end

    // boundary text bytes, first byte in the low bits of word zero
    always_comb begin
        for (int j = 0; j < MAX_BOUNDARY; j++) begin
            w_bnd_byte[j] = r_bnd_word[j / 8][(j % 8) * 8 +: 8];
        end
    end

    // expected byte at each window tap, newest byte at tap zero:
    // the two oldest taps of the delimiter are the hyphens
    always_comb begin
        for (int p = 0; p < WIN; p++) begin
            w_expect[p] = '0;
            if (p + 2 >= int'(w_dlen)) begin
                w_expect[p] = mbe_pkg::CH_DASH;
            end else begin
                for (int j = 0; j < MAX_BOUNDARY; j++) begin
                    if (j + p + 3 == int'(w_dlen)) begin
                        w_expect[p] = w_expect[p] | w_bnd_byte[j];
                    end
                end
            end
        end
    end

    // shifted window, then parallel compare of the taps inside the delimiter
    always_comb begin
        n_win[0] = r_in_byte;
        for (int p = 1; p < WIN; p++) begin
            n_win[p] = r_win[p-1];
        end
        w_pat_ok = 1'b1;
        for (int p = 0; p < WIN; p++) begin
            if (p < int'(w_dlen) && n_win[p] != w_expect[p]) begin
                w_pat_ok = 1'b0;
            end
        end
        w_head_ok = (n_win[3] == mbe_pkg::CH_CR) && (n_win[2] == mbe_pkg::CH_LF) &&
                    (n_win[1] == mbe_pkg::CH_CR) && (n_win[0] == mbe_pkg::CH_LF);
        // oldest held byte, the one that leaves the hold-back window
        w_release = '0;
        for (int p = 0; p < WIN; p++) begin
            if (p + 1 == int'(w_dlen)) begin
                w_release = w_release | r_win[p];
            end
        end
    end

    // saturating byte count and size limit check
    always_comb begin
        w_count_inc = (r_count != '1) ? r_count + CNT_W'(1) : r_count;
        w_over      = (r_size_limit != '0) && (CMP_W'(w_count_inc) > CMP_W'(r_size_limit));
    end

    // parser step for the byte in the input register
    always_comb begin
        n_phase      = r_phase;
        n_fill       = r_fill;
        n_count      = r_count;
        n_data_valid = 1'b0;
        n_file_byte  = '0;
        n_status     = mbe_pkg::ST_RUNNING;
        w_fill_base  = r_fill;

        if (r_phase == PH_DONE || r_phase == PH_ABORT || r_phase == PH_ENDED) begin
            n_status = mbe_pkg::ST_IGNORED;
        end else begin
            n_count = w_count_inc;
            if (w_over) begin
                // this byte is not parsed, held bytes are dropped
                n_phase  = PH_ABORT;
                n_fill   = '0;
                n_status = mbe_pkg::ST_ABORT;
            end else begin
                unique case (r_phase)
                    PH_SEEK: begin
                        n_fill = (r_fill >= w_dlen) ? w_dlen : r_fill + FW'(1);
                        if (w_pat_ok && n_fill >= w_dlen) begin
                            n_phase = PH_HEAD;
                            n_fill  = '0;
                        end
                    end
                    PH_HEAD: begin
                        n_fill = (r_fill >= FW'(4)) ? FW'(4) : r_fill + FW'(1);
                        if (w_head_ok && n_fill >= FW'(4)) begin
                            n_phase = PH_DATA;
                            n_fill  = '0;
                        end
                    end
                    default: begin
                        // file data: release the oldest byte once the window is full
                        if (r_fill >= w_dlen) begin
                            n_data_valid = 1'b1;
                            n_file_byte  = w_release;
                            w_fill_base  = w_dlen - FW'(1);
                        end
                        n_fill = (w_fill_base >= w_dlen) ? w_dlen : w_fill_base + FW'(1);
                        if (w_pat_ok && n_fill >= w_dlen) begin
                            n_phase  = PH_DONE;
                            n_fill   = '0;
                            n_status = mbe_pkg::ST_DONE;
                        end
                    end
                endcase
                // body ended before the closing delimiter
                if (r_in_last && n_phase != PH_DONE) begin
                    n_phase  = PH_ENDED;
                    n_fill   = '0;
                    n_status = mbe_pkg::ST_ENDED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_len    <= mbe_pkg::BND_LEN_W'(1);
            for (int k = 0; k < mbe_pkg::WORD_CNT; k++) begin
                r_bnd_word[k] <= '0;
            end
            r_size_limit <= '0;
            r_in_valid   <= 1'b0;
            r_phase      <= PH_SEEK;
            r_fill       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration transfer
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index) inside
                    mbe_pkg::CFG_LENGTH: begin
                        r_bnd_len <= i_cfg_data[mbe_pkg::BND_LEN_W-1:0];
                    end
                    [mbe_pkg::CFG_WORD0:mbe_pkg::CFG_WORD5]: begin
                        r_bnd_word[w_word_sel] <= i_cfg_data;
                    end
                    mbe_pkg::CFG_LIMIT: begin
                        r_size_limit <= i_cfg_data[mbe_pkg::LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // input register
            if (w_in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            // parser state and result register
            if (w_fire) begin
                r_phase     <= n_phase;
                r_fill      <= n_fill;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload, no reset needed
        if (w_in_xfer) begin
            r_in_byte <= i_body_byte;
            r_in_last <= i_last_byte;
        end
        if (w_fire) begin
            r_win        <= n_win;
            r_data_valid <= n_data_valid;
            r_file_byte  <= n_file_byte;
            r_status     <= n_status;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // the input side only stalls while a result waits on the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    // a finished transfer never resumes until reset
    a_terminal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_ABORT || r_phase == PH_ENDED)
        |=> (r_phase == PH_DONE || r_phase == PH_ABORT || r_phase == PH_ENDED))
        else $error("parser left a terminal phase");

    // file bytes only come with running, closing or ended status
    a_data_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_data_valid) |->
        (o_status == mbe_pkg::ST_RUNNING || o_status == mbe_pkg::ST_DONE ||
         o_status == mbe_pkg::ST_ENDED))
        else $error("file byte released with abort or ignored status");

    // fill never exceeds the hold-back window
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (int'(r_fill) <= WIN))
        else $error("window fill beyond window depth");

endmodule
